@@ src/gcb_pkg.sv @@
// Shared types and constants for the grid cell binning block.
// No dependencies; used by the interfaces, the top level and the checker.
package gcb_pkg;

   localparam int unsigned COORD_W    = 16;
   localparam int unsigned ID_W       = 16;
   localparam int unsigned CSR_AW     = 3;
   localparam int unsigned CSR_DW     = 16;
   localparam int unsigned CNT_W      = 9;
   localparam int unsigned IDX_OUT_W  = 8;
   localparam int unsigned SLOT_OUT_W = 4;
   localparam int unsigned RES_CNT_W  = 6;
   localparam int unsigned QUO_W      = 18;
   localparam int unsigned IDX_W      = 24;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_CELL_W   = 3'd3,
      CSR_CELL_H   = 3'd4,
      CSR_CELL_D   = 3'd5,
      CSR_CELLS_X  = 3'd6,
      CSR_CELLS_Y  = 3'd7
   } csr_index_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_CLEAR  = 1'b1
   } func_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0]  cell_index;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  dropped;
      logic                  truncated;
      logic                  none_hit;
      logic                  last;
   } result_type;

endpackage

@@ src/gcb_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on gcb_pkg for field widths.
interface gcb_req_if;
   logic                                valid;
   logic                                ready;
   logic                                func;
   logic [gcb_pkg::ID_W-1:0]            collider_id;
   logic signed [gcb_pkg::COORD_W-1:0]  box_min_x;
   logic signed [gcb_pkg::COORD_W-1:0]  box_min_y;
   logic signed [gcb_pkg::COORD_W-1:0]  box_min_z;
   logic signed [gcb_pkg::COORD_W-1:0]  box_max_x;
   logic signed [gcb_pkg::COORD_W-1:0]  box_max_y;
   logic signed [gcb_pkg::COORD_W-1:0]  box_max_z;

   modport source (output valid, func, collider_id, box_min_x, box_min_y, box_min_z,
                   box_max_x, box_max_y, box_max_z, input ready);
   modport sink (input valid, func, collider_id, box_min_x, box_min_y, box_min_z,
                 box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface gcb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gcb_pkg::IDX_OUT_W-1:0]     cell_index;
   logic [gcb_pkg::SLOT_OUT_W-1:0]    slot;
   logic                              dropped;
   logic                              truncated;
   logic                              none_hit;
   logic                              last;

   modport source (output valid, cell_index, slot, dropped, truncated, none_hit, last,
                   input ready);
   modport sink (input valid, cell_index, slot, dropped, truncated, none_hit, last,
                 output ready);
endinterface

@@ src/gcb_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

@@ src/grid_cell_binning.sv @@
// Insert: the shared bit-serial divider runs four divisions (six when DEPTH_CELLS > 1),
// then the clamp, multiply, z-offset and base steps; each covered cell then takes a read
// and a write step, the write waiting while the response output is stalled. Clear: the
// fill store is swept, then one acknowledge beat. Reset is synchronous; after it the fill
// store is swept while no request is taken. Configuration writes are taken at any time.
module grid_cell_binning #(
   parameter int MAX_CELLS      = 256,
   parameter int SLOTS_PER_CELL = 16,
   parameter int DEPTH_CELLS    = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   gcb_req_if.sink                       req_bus,
   gcb_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [gcb_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [gcb_pkg::CSR_DW-1:0]    csr_wdata
);

   localparam int FILL_W   = $clog2(SLOTS_PER_CELL + 1);
   localparam int CELL_AW  = MAX_CELLS > 1 ? $clog2(MAX_CELLS) : 1;
   localparam int MEM_D    = MAX_CELLS * SLOTS_PER_CELL;
   localparam int MEM_AW   = MEM_D > 1 ? $clog2(MEM_D) : 1;
   localparam int Z_W      = DEPTH_CELLS > 1 ? $clog2(DEPTH_CELLS) : 1;
   localparam int NDIV     = DEPTH_CELLS > 1 ? 6 : 4;
   localparam int IW       = gcb_pkg::IDX_W;
   localparam int QW       = gcb_pkg::QUO_W;
   localparam int CW       = gcb_pkg::CNT_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV, S_CLAMP, S_MUL, S_ZOFF, S_BASE, S_RD, S_WR, S_NONE
   } state_type;

   state_type state_ff;
   logic      id_ack_pending_ff;

   logic [CELL_AW-1:0] clr_cnt_ff;
   logic signed [15:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [15:0]        cell_w_ff, cell_h_ff, cell_d_ff;
   logic [CW-1:0]      cells_x_ff, cells_y_ff;

   logic [gcb_pkg::ID_W-1:0] id_ff;
   logic signed [15:0]       corner_ff [6];
   logic [2:0]               div_sel_ff;
   logic [4:0]               div_cnt_ff;
   logic [15:0]              rem_ff, quo_ff, dvs_ff;
   logic                     neg_ff;
   logic signed [QW-1:0]     q_ff [6];

   logic [CW-1:0]  x0_ff, x1_ff, y0_ff, y1_ff, x_ff, y_ff;
   logic [Z_W-1:0] z0_ff, z1_ff, z_ff;
   logic [17:0]    nxny_ff, yoff_ff;
   logic [IW-1:0]  zoff_ff, idx_ff, row_ff, plane_ff;
   logic [gcb_pkg::RES_CNT_W-1:0] k_ff;

   logic                 rsp_valid_ff;
   gcb_pkg::result_type  rsp_data_ff;

   // Divider operand selection and one restoring step.
   logic signed [15:0] sel_corner, sel_origin;
   logic [15:0]        sel_size;
   logic signed [16:0] diff;
   logic [16:0]        shifted;
   logic               ge;
   logic [15:0]        rem_in, quo_in;
   logic signed [QW-1:0] quot_signed;

   always_comb begin
      sel_corner = corner_ff[div_sel_ff];
      case (div_sel_ff[2:1])
         2'd0:    begin sel_origin = origin_x_ff; sel_size = cell_w_ff; end
         2'd1:    begin sel_origin = origin_y_ff; sel_size = cell_h_ff; end
         default: begin sel_origin = origin_z_ff; sel_size = cell_d_ff; end
      endcase
      diff    = {sel_corner[15], sel_corner} - {sel_origin[15], sel_origin};
      shifted = {rem_ff, quo_ff[15]};
      ge      = shifted >= {1'b0, dvs_ff};
      rem_in  = ge ? 16'(shifted - {1'b0, dvs_ff}) : shifted[15:0];
      quo_in  = {quo_ff[14:0], ge};
      quot_signed = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   end

   // Clamping of the quotients to the grid.
   logic signed [QW-1:0] x0c, x1c, y0c, y1c, z0c, z1c, zq0, zq1, nxm1, nym1;
   logic                 empty;

   always_comb begin
      zq0  = DEPTH_CELLS > 1 ? q_ff[4] : '0;
      zq1  = DEPTH_CELLS > 1 ? q_ff[5] : '0;
      nxm1 = $signed({{(QW-CW){1'b0}}, cells_x_ff}) - QW'(1);
      nym1 = $signed({{(QW-CW){1'b0}}, cells_y_ff}) - QW'(1);
      x0c  = q_ff[0] < 0 ? '0 : q_ff[0];
      y0c  = q_ff[2] < 0 ? '0 : q_ff[2];
      z0c  = zq0 < 0 ? '0 : zq0;
      x1c  = q_ff[1] > nxm1 ? nxm1 : q_ff[1];
      y1c  = q_ff[3] > nym1 ? nym1 : q_ff[3];
      z1c  = zq1 > QW'(DEPTH_CELLS - 1) ? QW'(DEPTH_CELLS - 1) : zq1;
      empty = (x0c > x1c) || (y0c > y1c) || (z0c > z1c);
   end

   // Next covered cell in z, y, x order; the index rises strictly along the walk.
   logic          has_next, more;
   logic [IW-1:0] nidx, start_idx;

   always_comb begin
      has_next = 1'b1;
      if (x_ff < x1_ff) begin
         nidx = idx_ff + IW'(1);
      end else if (y_ff < y1_ff) begin
         nidx = row_ff + IW'(cells_x_ff);
      end else if (z_ff < z1_ff) begin
         nidx = plane_ff + IW'(nxny_ff);
      end else begin
         nidx     = idx_ff;
         has_next = 1'b0;
      end
      more      = has_next && (nidx < IW'(MAX_CELLS));
      start_idx = zoff_ff + IW'(yoff_ff) + IW'(x0_ff);
   end

   // Fill counts and member lists.
   logic               fill_we, fill_re;
   logic [CELL_AW-1:0] fill_waddr;
   logic [FILL_W-1:0]  fill_wdata, fill_rdata;
   logic               full, out_free, mem_we;
   logic [MEM_AW-1:0]  mem_waddr;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign full     = fill_rdata >= FILL_W'(SLOTS_PER_CELL);
   assign fill_re  = (state_ff == S_RD);
   assign mem_we   = (state_ff == S_WR) && out_free && !full;
   assign mem_waddr = MEM_AW'(idx_ff[CELL_AW-1:0]) * MEM_AW'(SLOTS_PER_CELL)
                    + MEM_AW'(fill_rdata);

   always_comb begin
      if (state_ff == S_CLEAR) begin
         fill_we    = 1'b1;
         fill_waddr = clr_cnt_ff;
         fill_wdata = '0;
      end else begin
         fill_we    = mem_we;
         fill_waddr = idx_ff[CELL_AW-1:0];
         fill_wdata = fill_rdata + FILL_W'(1);
      end
   end

   gcb_ram #(.WIDTH(FILL_W), .DEPTH(MAX_CELLS)) u_fill (
      .clock (clock),
      .we    (fill_we),
      .waddr (fill_waddr),
      .wdata (fill_wdata),
      .re    (fill_re),
      .raddr (idx_ff[CELL_AW-1:0]),
      .rdata (fill_rdata)
   );

   gcb_ram #(.WIDTH(gcb_pkg::ID_W), .DEPTH(MEM_D)) u_members (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (id_ff),
      .re    (1'b0),
      .raddr ('0),
      .rdata ()
   );

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cell_index = rsp_data_ff.cell_index;
   assign rsp_bus.slot       = rsp_data_ff.slot;
   assign rsp_bus.dropped    = rsp_data_ff.dropped;
   assign rsp_bus.truncated  = rsp_data_ff.truncated;
   assign rsp_bus.none_hit   = rsp_data_ff.none_hit;
   assign rsp_bus.last       = rsp_data_ff.last;

   logic last_cell;
   assign last_cell = !more || (k_ff == '1);

   always_ff @(posedge clock) begin
      if (csr_we) begin
         case (gcb_pkg::csr_index_type'(csr_addr))
            gcb_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            gcb_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            gcb_pkg::CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            gcb_pkg::CSR_CELL_W:   cell_w_ff   <= csr_wdata;
            gcb_pkg::CSR_CELL_H:   cell_h_ff   <= csr_wdata;
            gcb_pkg::CSR_CELL_D:   cell_d_ff   <= csr_wdata;
            gcb_pkg::CSR_CELLS_X:  cells_x_ff  <= csr_wdata[CW-1:0];
            gcb_pkg::CSR_CELLS_Y:  cells_y_ff  <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end

      if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_ff <= clr_cnt_ff + CELL_AW'(1);
            if (clr_cnt_ff == CELL_AW'(MAX_CELLS - 1)) begin
               state_ff <= S_NONE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               id_ff        <= req_bus.collider_id;
               corner_ff[0] <= req_bus.box_min_x;
               corner_ff[1] <= req_bus.box_max_x;
               corner_ff[2] <= req_bus.box_min_y;
               corner_ff[3] <= req_bus.box_max_y;
               corner_ff[4] <= req_bus.box_min_z;
               corner_ff[5] <= req_bus.box_max_z;
               div_sel_ff   <= '0;
               div_cnt_ff   <= '0;
               clr_cnt_ff   <= '0;
               state_ff     <= (req_bus.func == gcb_pkg::FUNC_CLEAR) ? S_CLEAR : S_DIV;
            end
         end
         S_DIV: begin
            div_cnt_ff <= div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd0) begin
               neg_ff <= diff[16];
               quo_ff <= diff[16] ? 16'(-diff) : diff[15:0];
               rem_ff <= '0;
               dvs_ff <= (sel_size == '0) ? 16'd1 : sel_size;
            end else if (div_cnt_ff <= 5'd16) begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
            end else begin
               q_ff[div_sel_ff] <= quot_signed;
               div_cnt_ff       <= '0;
               div_sel_ff       <= div_sel_ff + 3'd1;
               if (div_sel_ff == 3'(NDIV - 1)) begin
                  state_ff <= S_CLAMP;
               end
            end
         end
         S_CLAMP: begin
            // Bounds are kept narrow; they are only used when the range is not empty.
            x0_ff <= x0c[CW-1:0];
            x1_ff <= x1c[CW-1:0];
            y0_ff <= y0c[CW-1:0];
            y1_ff <= y1c[CW-1:0];
            z0_ff <= z0c[Z_W-1:0];
            z1_ff <= z1c[Z_W-1:0];
            state_ff <= empty ? S_NONE : S_MUL;
         end
         S_MUL: begin
            nxny_ff  <= cells_x_ff * cells_y_ff;
            yoff_ff  <= y0_ff * cells_x_ff;
            state_ff <= S_ZOFF;
         end
         S_ZOFF: begin
            zoff_ff  <= IW'(z0_ff) * IW'(nxny_ff);
            state_ff <= S_BASE;
         end
         S_BASE: begin
            idx_ff   <= start_idx;
            row_ff   <= start_idx;
            plane_ff <= start_idx;
            x_ff     <= x0_ff;
            y_ff     <= y0_ff;
            z_ff     <= z0_ff;
            k_ff     <= '0;
            state_ff <= (start_idx >= IW'(MAX_CELLS)) ? S_NONE : S_RD;
         end
         S_RD: begin
            state_ff <= S_WR;
         end
         S_WR: begin
            if (out_free) begin
               rsp_valid_ff           <= 1'b1;
               rsp_data_ff.cell_index <= idx_ff[gcb_pkg::IDX_OUT_W-1:0];
               rsp_data_ff.slot       <= full ? '0 : fill_rdata[gcb_pkg::SLOT_OUT_W-1:0];
               rsp_data_ff.dropped    <= full;
               rsp_data_ff.truncated  <= more && (k_ff == '1);
               rsp_data_ff.none_hit   <= 1'b0;
               rsp_data_ff.last       <= last_cell;
               k_ff                   <= k_ff + 1'b1;
               idx_ff                 <= nidx;
               if (x_ff < x1_ff) begin
                  x_ff <= x_ff + 1'b1;
               end else if (y_ff < y1_ff) begin
                  x_ff   <= x0_ff;
                  y_ff   <= y_ff + 1'b1;
                  row_ff <= nidx;
               end else begin
                  x_ff     <= x0_ff;
                  y_ff     <= y0_ff;
                  z_ff     <= z_ff + 1'b1;
                  row_ff   <= nidx;
                  plane_ff <= nidx;
               end
               state_ff <= last_cell ? S_IDLE : S_RD;
            end
         end
         S_NONE: begin
            // Empty box, or acknowledge of a clear; the sweep after reset sends none.
            if (out_free) begin
               rsp_valid_ff <= id_ack_pending_ff;
               rsp_data_ff  <= '{cell_index: '0, slot: '0, dropped: 1'b0,
                                 truncated: 1'b0, none_hit: 1'b1, last: 1'b1};
               state_ff     <= S_IDLE;
            end
         end
         default: state_ff <= S_IDLE;
      endcase

      if (state_ff == S_IDLE && req_bus.valid) begin
         id_ack_pending_ff <= 1'b1;
      end

      if (reset) begin
         state_ff          <= S_CLEAR;
         clr_cnt_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
         id_ack_pending_ff <= 1'b0;
         origin_x_ff       <= '0;
         origin_y_ff       <= '0;
         origin_z_ff       <= '0;
         cell_w_ff         <= 16'd500;
         cell_h_ff         <= 16'd500;
         cell_d_ff         <= 16'd1;
         cells_x_ff        <= CW'(10);
         cells_y_ff        <= CW'(10);
      end
   end

endmodule

@@ src/gcb_checker.sv @@
// Port-level checks for grid_cell_binning, attached by the bind at the end.
// Depends on gcb_pkg for field widths.
module gcb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [gcb_pkg::IDX_OUT_W-1:0]     cell_index,
   input logic [gcb_pkg::SLOT_OUT_W-1:0]    slot,
   input logic                              dropped,
   input logic                              truncated,
   input logic                              none_hit,
   input logic                              last
);

   // A stalled beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({cell_index, slot, dropped, truncated, none_hit, last}))
      else $error("response beat changed while stalled");

   // Reset starts the sweep: nothing is offered and nothing is taken.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("block active right after reset");

   a_none_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && none_hit |-> last && cell_index == '0 && slot == '0 &&
         !dropped && !truncated)
      else $error("none_hit beat carries cell data");

   a_truncated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && truncated |-> last && !none_hit)
      else $error("truncated flag on a beat that is not the final cell");

   a_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dropped |-> slot == '0 && !none_hit)
      else $error("dropped beat with a slot");

endmodule

bind grid_cell_binning gcb_checker u_gcb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .cell_index (rsp_bus.cell_index),
   .slot       (rsp_bus.slot),
   .dropped    (rsp_bus.dropped),
   .truncated  (rsp_bus.truncated),
   .none_hit   (rsp_bus.none_hit),
   .last       (rsp_bus.last)
);

@@ bench/gcb_bench_if.sv @@
// Bench-side note: the channel interfaces themselves live in src/gcb_if.sv.
// This file holds a small package of bench helpers; depends on gcb_pkg.
package gcb_bench_pkg;
   import gcb_pkg::*;

   typedef struct {
      func_type         func;
      logic [15:0]      collider_id;
      logic signed [15:0] min_x, min_y, min_z, max_x, max_y, max_z;
   } box_item_type;
endpackage

@@ bench/grid_cell_binning_tb.sv @@
// Testbench for grid_cell_binning: directed and random boxes, clears and grid settings.
// Depends on gcb_pkg, gcb_bench_pkg, gcb_if and the block itself.
module grid_cell_binning_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gcb_pkg::*;
   import gcb_bench_pkg::*;

   localparam int MAX_CELLS = 256;
   localparam int SLOTS = 16;
   localparam int CELL_LIMIT = 64;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   gcb_req_if req_bus ();
   gcb_rsp_if rsp_bus ();

   grid_cell_binning uut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Shadow copy of the grid configuration and the per-cell fill counts.
   logic signed [15:0] org_x, org_y, org_z;
   logic [15:0] size_w, size_h, size_d;
   logic [8:0] count_x, count_y;
   int unsigned fill_count [MAX_CELLS];
   result_type pending_results [$];

   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;
   bit rsp_idling_on = 1'b1;
   int rsp_hold = 0;
   bit send_idling_on = 1'b1;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int axis_cell(logic signed [15:0] corner, logic signed [15:0] org,
                                    logic [15:0] size);
      int d;
      int s;
      d = int'(corner) - int'(org);
      s = (size == 0) ? 1 : int'(size);
      return d / s;
   endfunction

   // Works out the beats caused by one box or clear and updates the fill counts.
   task automatic bin_box(input box_item_type it);
      int x0, x1, y0, y1, nx, ny, k, idx;
      bit stop;
      result_type r;
      result_type beats [$];
      nx = int'(count_x);
      ny = int'(count_y);
      stop = 1'b0;
      if (it.func == FUNC_CLEAR) begin
         foreach (fill_count[i]) fill_count[i] = 0;
         r = '0;
         r.none_hit = 1'b1;
         r.last = 1'b1;
         pending_results.push_back(r);
         return;
      end
      x0 = axis_cell(it.min_x, org_x, size_w);
      x1 = axis_cell(it.max_x, org_x, size_w);
      y0 = axis_cell(it.min_y, org_y, size_h);
      y1 = axis_cell(it.max_y, org_y, size_h);
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > nx - 1) x1 = nx - 1;
      if (y1 > ny - 1) y1 = ny - 1;
      for (int y = y0; y <= y1 && !stop; y++) begin
         for (int x = x0; x <= x1 && !stop; x++) begin
            idx = y * nx + x;
            if (idx >= MAX_CELLS) continue;
            if (beats.size() == CELL_LIMIT) begin
               beats[CELL_LIMIT-1].truncated = 1'b1;
               stop = 1'b1;
               break;
            end
            r = '0;
            r.cell_index = idx[7:0];
            if (fill_count[idx] >= SLOTS) begin
               r.dropped = 1'b1;
            end else begin
               r.slot = fill_count[idx][3:0];
               fill_count[idx]++;
            end
            beats.push_back(r);
         end
      end
      if (beats.size() == 0) begin
         r = '0;
         r.none_hit = 1'b1;
         beats.push_back(r);
      end
      beats[beats.size()-1].last = 1'b1;
      foreach (beats[i]) pending_results.push_back(beats[i]);
   endtask

   // Stops offering and waits until every expected beat has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0 && !timed_out) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [15:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_addr <= which;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (which)
         CSR_ORIGIN_X: org_x = value;
         CSR_ORIGIN_Y: org_y = value;
         CSR_ORIGIN_Z: org_z = value;
         CSR_CELL_W: size_w = value;
         CSR_CELL_H: size_h = value;
         CSR_CELL_D: size_d = value;
         CSR_CELLS_X: count_x = value[8:0];
         default: count_y = value[8:0];
      endcase
      @(posedge clock);
   endtask

   // Valid stays high after the accepting edge until the next beat or a wait replaces it.
   task automatic send_box(input box_item_type it);
      int gap;
      if (send_idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= it.func;
      req_bus.collider_id <= it.collider_id;
      req_bus.box_min_x <= it.min_x;
      req_bus.box_min_y <= it.min_y;
      req_bus.box_min_z <= it.min_z;
      req_bus.box_max_x <= it.max_x;
      req_bus.box_max_y <= it.max_y;
      req_bus.box_max_z <= it.max_z;
      do @(posedge clock); while (!req_bus.ready);
      bin_box(it);
   endtask

   // Waits for every beat to drain, then for the longest clear sweep to finish.
   task automatic drain_and_settle();
      wait_drained();
      repeat (MAX_CELLS + 80) @(posedge clock);
   endtask

   function automatic box_item_type make_box(input func_type f, input int x0, input int y0,
                                             input int x1, input int y1);
      box_item_type it;
      it.func = f;
      it.collider_id = 16'($urandom);
      it.min_x = 16'(x0);
      it.min_y = 16'(y0);
      it.max_x = 16'(x1);
      it.max_y = 16'(y1);
      it.min_z = 16'($urandom);
      it.max_z = 16'($urandom);
      return it;
   endfunction

   function automatic box_item_type random_box();
      int span_x, span_y, cx, cy;
      span_x = int'(size_w == 0 ? 1 : size_w) * int'(count_x);
      span_y = int'(size_h == 0 ? 1 : size_h) * int'(count_y);
      if ($urandom_range(0, 7) == 0) begin
         return make_box(FUNC_INSERT, $signed(16'($urandom)), $signed(16'($urandom)),
                         $signed(16'($urandom)), $signed(16'($urandom)));
      end
      cx = int'(org_x) + $urandom_range(0, span_x) - span_x / 8;
      cy = int'(org_y) + $urandom_range(0, span_y) - span_y / 8;
      if (cx > 32767) cx = 32767;
      if (cy > 32767) cy = 32767;
      return make_box(FUNC_INSERT, cx, cy, cx + $urandom_range(0, span_x / 3),
                      cy + $urandom_range(0, span_y / 3));
   endfunction

   task automatic test_directed_extremes();
      box_item_type it;
      send_box(make_box(FUNC_INSERT, 0, 0, 0, 0));
      send_box(make_box(FUNC_INSERT, -32768, -32768, 32767, 32767));
      send_box(make_box(FUNC_INSERT, -32768, -32768, -1, -1));
      send_box(make_box(FUNC_INSERT, 5000, 0, 32767, 32767));
      send_box(make_box(FUNC_INSERT, 600, 600, 100, 100));
      send_box(make_box(FUNC_INSERT, 499, 499, 500, 500));
      // Keep hitting one cell until it overflows its slots.
      for (int i = 0; i < 18; i++) send_box(make_box(FUNC_INSERT, 10, 10, 20, 20));
      it = make_box(FUNC_CLEAR, 0, 0, 0, 0);
      it.collider_id = 16'hFFFF;
      send_box(it);
      send_box(make_box(FUNC_INSERT, 10, 10, 20, 20));
      drain_and_settle();
   endtask

   task automatic test_zero_sizes();
      write_reg(CSR_CELL_W, 16'd0);
      write_reg(CSR_CELL_H, 16'd0);
      write_reg(CSR_CELL_D, 16'd0);
      write_reg(CSR_ORIGIN_Z, 16'h8000);
      send_box(make_box(FUNC_INSERT, 0, 0, 9, 9));
      send_box(make_box(FUNC_INSERT, 3, 2, 3, 2));
      write_reg(CSR_CELLS_X, 9'd0);
      send_box(make_box(FUNC_INSERT, 0, 0, 9, 9));
      write_reg(CSR_CELLS_X, 9'd256);
      write_reg(CSR_CELLS_Y, 9'd256);
      send_box(make_box(FUNC_INSERT, 250, 0, 300, 2));
      drain_and_settle();
   endtask

   task automatic run_random_phase(input int n);
      box_item_type it;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) it = make_box(FUNC_CLEAR, 0, 0, 0, 0);
         else it = random_box();
         send_box(it);
      end
      drain_and_settle();
   endtask

   task automatic test_random_configs();
      write_reg(CSR_ORIGIN_X, 16'h8000);
      write_reg(CSR_ORIGIN_Y, 16'h7FFF);
      write_reg(CSR_CELL_W, 16'hFFFF);
      write_reg(CSR_CELL_H, 16'hFFFF);
      write_reg(CSR_CELLS_X, 9'd1);
      write_reg(CSR_CELLS_Y, 9'd1);
      run_random_phase(10);
      for (int p = 0; p < 4; p++) begin
         write_reg(CSR_ORIGIN_X, 16'($urandom_range(0, 2000) - 1000));
         write_reg(CSR_ORIGIN_Y, 16'($urandom_range(0, 2000) - 1000));
         write_reg(CSR_ORIGIN_Z, 16'($urandom));
         write_reg(CSR_CELL_W, 16'($urandom_range(1, 300)));
         write_reg(CSR_CELL_H, 16'($urandom_range(1, 300)));
         write_reg(CSR_CELL_D, 16'($urandom));
         write_reg(CSR_CELLS_X, 9'($urandom_range(1, 20)));
         write_reg(CSR_CELLS_Y, 9'($urandom_range(1, 20)));
         run_random_phase(30);
      end
   endtask

   // The receiver holds off while the sender keeps offering boxes.
   task automatic test_backpressure();
      rsp_hold = 400;
      run_random_phase(10);
      send_box(make_box(FUNC_INSERT, 0, 0, 100, 100));
      wait_drained();
      send_box(make_box(FUNC_INSERT, 0, 0, 50, 50));
      drain_and_settle();
   endtask

   task automatic test_no_idling();
      send_idling_on = 1'b0;
      rsp_idling_on = 1'b0;
      run_random_phase(30);
   endtask

   // Response side: random ready bursts and one long hold-off on request.
   initial begin
      int burst;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end else if (rsp_idling_on && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 17);
            rsp_bus.ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.cell_index = rsp_bus.cell_index;
         got.slot = rsp_bus.slot;
         got.dropped = rsp_bus.dropped;
         got.truncated = rsp_bus.truncated;
         got.none_hit = rsp_bus.none_hit;
         got.last = rsp_bus.last;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected beat %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_INSERT;
      req_bus.collider_id = '0;
      req_bus.box_min_x = '0;
      req_bus.box_min_y = '0;
      req_bus.box_min_z = '0;
      req_bus.box_max_x = '0;
      req_bus.box_max_y = '0;
      req_bus.box_max_z = '0;
      org_x = 0; org_y = 0; org_z = 0;
      size_w = 500; size_h = 500; size_d = 1;
      count_x = 10; count_y = 10;
      foreach (fill_count[i]) fill_count[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_zero_sizes();
      test_random_configs();
      test_backpressure();
      test_no_idling();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
